@@ design/vpp_pkg.sv @@
`timescale 1ns / 1ps

package vpp_pkg;

    // Pulse limits in microseconds.
    localparam logic [11:0] ESC_PULSE_MIN      = 12'd1000;
    localparam logic [11:0] ESC_PULSE_MAX      = 12'd2000;
    localparam logic [11:0] VALVE_CLOSED_PULSE = 12'd1000;
    localparam logic [11:0] VALVE_OPEN_PULSE   = 12'd2000;

    // Datapath widths.
    localparam int ACC_W  = 40;   // integral accumulator, Q32.8
    localparam int SUM_W  = 58;   // pulse sum, Q.8
    localparam int PROD_W = 72;   // full gain product before the Q16 shift

    // Q.8 constants of the pulse sum and the integral window.
    localparam logic signed [SUM_W-1:0] SUM_BIAS = 58'sd256000;
    localparam logic signed [SUM_W-1:0] SUM_HI   = 58'sd512256;   // (max + 1) * 256
    localparam logic signed [SUM_W-1:0] SUM_LO   = 58'sd256000;   // min * 256
    localparam logic signed [24:0]      ERR_WIN  = 25'sd256000;

    localparam logic signed [SUM_W-1:0] ACC_MAX = 58'sd549755813887;
    localparam logic signed [SUM_W-1:0] ACC_MIN = -58'sd549755813888;

    // Phase codes on the result port.
    localparam logic [1:0] PHASE_INHALE    = 2'd0;
    localparam logic [1:0] PHASE_EXHALE    = 2'd1;
    localparam logic [1:0] PHASE_CYCLE_END = 2'd2;

    // Top multiplier chunk for each operand kind.
    localparam logic [1:0] CHUNK_ERR_TOP   = 2'd1;
    localparam logic [1:0] CHUNK_DERIV_TOP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DMUL,
        ST_MUL,
        ST_FOLD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_PROP,
        OP_INT,
        OP_DERIV
    } op_t;

    typedef enum logic [2:0] {
        REG_GAIN_PROP,
        REG_GAIN_INT,
        REG_GAIN_DERIV,
        REG_PEAK_TARGET,
        REG_BASELINE_TARGET,
        REG_RISE_DELAY_MS,
        REG_INHALE_MS,
        REG_EXHALE_MS
    } cfg_idx_t;

endpackage

@@ design/ventilator_pressure_pid.sv @@
`timescale 1ns / 1ps

// Pressure-controlled ventilation blower PID. Each request carries the breath
// cycle time, the loop rate and the airway pressure; the block picks the
// breath phase, runs one fixed-point PID step and returns one result with the
// clamped blower pulse, the valve pulse, the phase and the restart flag. All
// products go through a single 32x16 unsigned multiplier under a small
// sequencer: one pass for pressure change times loop rate, two passes each for
// the proportional and integral terms and three for the derivative term, with
// one fold step after each term. A request is taken only in the idle state, so
// the block finishes each request before it accepts the next; a finished result
// may wait in its register while the next request is accepted. Configuration
// writes are taken in any cycle, with cfg_ready always high.
module ventilator_pressure_pid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        cycle_time_ms,
    input  logic [13:0]        loop_rate_hz,
    input  logic signed [23:0] airway_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        blower_pulse_us,
    output logic [11:0]        valve_pulse_us,
    output logic [1:0]         phase,
    output logic               restart_cycle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers.
    logic [31:0] gain_prop_reg, gain_int_reg, gain_deriv_reg;
    logic [22:0] peak_target_reg, baseline_target_reg;
    logic [15:0] rise_delay_ms_reg, inhale_ms_reg, exhale_ms_reg;

    // Sequencer and datapath registers.
    vpp_pkg::state_t state_reg, state_next;
    vpp_pkg::op_t    op_reg, op_next;
    logic [1:0]      chunk_reg, chunk_next;
    logic [vpp_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic signed [vpp_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [vpp_pkg::ACC_W-1:0] integ_reg, integ_next;
    logic signed [23:0] prev_reg, prev_next;
    logic [23:0] err_mag_reg, err_mag_next;
    logic        err_neg_reg, err_neg_next;
    logic [23:0] diff_mag_reg, diff_mag_next;
    logic        diff_neg_reg, diff_neg_next;
    logic [13:0] rate_reg, rate_next;
    logic        int_en_reg, int_en_next;
    logic [39:0] dmag_reg, dmag_next;
    logic [1:0]  phase_reg, phase_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [11:0] blower_reg, blower_next;
    logic [11:0] valve_reg, valve_next;
    logic [1:0]  out_phase_reg, out_phase_next;
    logic        restart_reg, restart_next;

    // Combinational datapath signals.
    logic [16:0]        exh_end;
    logic               in_inhale, in_exhale;
    logic [1:0]         phase_in;
    logic [22:0]        target;
    logic signed [24:0] err, diff;
    logic [31:0]        g_sel, g_mag;
    logic               g_neg, x_neg, prod_neg;
    logic [39:0]        x_mag;
    logic [31:0]        mul_a;
    logic [15:0]        mul_b;
    logic [47:0]        mul_p;
    logic [vpp_pkg::PROD_W-1:0]       acc_shift;
    logic signed [vpp_pkg::SUM_W-1:0] term, int_sum, total;
    logic               out_free;

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != vpp_pkg::ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign blower_pulse_us = blower_reg;
    assign valve_pulse_us  = valve_reg;
    assign phase           = out_phase_reg;
    assign restart_cycle   = restart_reg;
    assign out_free        = !out_valid_reg || !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg       <= '0;
            gain_int_reg        <= '0;
            gain_deriv_reg      <= '0;
            peak_target_reg     <= '0;
            baseline_target_reg <= '0;
            rise_delay_ms_reg   <= '0;
            inhale_ms_reg       <= 16'd1000;
            exhale_ms_reg       <= 16'd2000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (vpp_pkg::cfg_idx_t'(cfg_index))
                vpp_pkg::REG_GAIN_PROP:       gain_prop_reg       <= cfg_data;
                vpp_pkg::REG_GAIN_INT:        gain_int_reg        <= cfg_data;
                vpp_pkg::REG_GAIN_DERIV:      gain_deriv_reg      <= cfg_data;
                vpp_pkg::REG_PEAK_TARGET:     peak_target_reg     <= cfg_data[22:0];
                vpp_pkg::REG_BASELINE_TARGET: baseline_target_reg <= cfg_data[22:0];
                vpp_pkg::REG_RISE_DELAY_MS:   rise_delay_ms_reg   <= cfg_data[15:0];
                vpp_pkg::REG_INHALE_MS:       inhale_ms_reg       <= cfg_data[15:0];
                vpp_pkg::REG_EXHALE_MS:       exhale_ms_reg       <= cfg_data[15:0];
                default:                      ;
            endcase
        end
    end

    // Phase selection and error terms for the incoming request.
    always_comb
    begin
        exh_end   = {1'b0, inhale_ms_reg} + {1'b0, exhale_ms_reg};
        in_inhale = (cycle_time_ms > rise_delay_ms_reg) && (cycle_time_ms <= inhale_ms_reg);
        in_exhale = (cycle_time_ms > inhale_ms_reg) && ({1'b0, cycle_time_ms} <= exh_end);
        if (in_inhale)
        begin
            phase_in = vpp_pkg::PHASE_INHALE;
            target   = peak_target_reg;
        end
        else if (in_exhale)
        begin
            phase_in = vpp_pkg::PHASE_EXHALE;
            target   = baseline_target_reg;
        end
        else
        begin
            phase_in = vpp_pkg::PHASE_CYCLE_END;
            target   = baseline_target_reg;
        end
        err  = $signed({2'b00, target}) - $signed({airway_pressure[23], airway_pressure});
        diff = $signed({airway_pressure[23], airway_pressure}) - $signed({prev_reg[23], prev_reg});
    end

    // Shared multiplier and the terms built from its accumulated product.
    always_comb
    begin
        case (op_reg)
            vpp_pkg::OP_PROP:  g_sel = gain_prop_reg;
            vpp_pkg::OP_INT:   g_sel = gain_int_reg;
            vpp_pkg::OP_DERIV: g_sel = gain_deriv_reg;
            default:           g_sel = gain_prop_reg;
        endcase
        g_neg = g_sel[31];
        g_mag = g_neg ? 32'(-g_sel) : g_sel;

        if (op_reg == vpp_pkg::OP_DERIV)
        begin
            x_mag = dmag_reg;
            x_neg = diff_neg_reg;
        end
        else
        begin
            x_mag = {16'b0, err_mag_reg};
            x_neg = err_neg_reg;
        end
        prod_neg = g_neg ^ x_neg;

        if (state_reg == vpp_pkg::ST_DMUL)
        begin
            mul_a = {8'b0, diff_mag_reg};
            mul_b = {2'b0, rate_reg};
        end
        else
        begin
            mul_a = g_mag;
            case (chunk_reg)
                2'd0:    mul_b = x_mag[15:0];
                2'd1:    mul_b = x_mag[31:16];
                default: mul_b = {8'b0, x_mag[39:32]};
            endcase
        end
        mul_p = {16'b0, mul_a} * {32'b0, mul_b};

        // The product is accumulated most significant chunk first.
        acc_shift = {acc_reg[vpp_pkg::PROD_W-17:0], 16'b0} + {24'b0, mul_p};

        // Dropping the low 16 bits of the magnitude truncates toward zero.
        term = $signed({2'b00, acc_reg[vpp_pkg::PROD_W-1:16]});
        if (prod_neg)
        begin
            term = -term;
        end

        int_sum = $signed({{(vpp_pkg::SUM_W-vpp_pkg::ACC_W){integ_reg[vpp_pkg::ACC_W-1]}},
                           integ_reg}) + term;
        total   = sum_reg + $signed({{(vpp_pkg::SUM_W-vpp_pkg::ACC_W){integ_reg[vpp_pkg::ACC_W-1]}},
                                     integ_reg});
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vpp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vpp_pkg::ST_DMUL;
                end
            end
            vpp_pkg::ST_DMUL: state_next = vpp_pkg::ST_MUL;
            vpp_pkg::ST_MUL:
            begin
                if (chunk_reg == 2'd0)
                begin
                    state_next = vpp_pkg::ST_FOLD;
                end
            end
            vpp_pkg::ST_FOLD:
            begin
                if (op_reg == vpp_pkg::OP_DERIV)
                begin
                    state_next = vpp_pkg::ST_DONE;
                end
                else
                begin
                    state_next = vpp_pkg::ST_MUL;
                end
            end
            vpp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = vpp_pkg::ST_IDLE;
                end
            end
            default: state_next = vpp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result register updates.
    always_comb
    begin
        op_next        = op_reg;
        chunk_next     = chunk_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        err_mag_next   = err_mag_reg;
        err_neg_next   = err_neg_reg;
        diff_mag_next  = diff_mag_reg;
        diff_neg_next  = diff_neg_reg;
        rate_next      = rate_reg;
        int_en_next    = int_en_reg;
        dmag_next      = dmag_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        blower_next    = blower_reg;
        valve_next     = valve_reg;
        out_phase_next = out_phase_reg;
        restart_next   = restart_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            vpp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    phase_next    = phase_in;
                    err_neg_next  = err[24];
                    err_mag_next  = err[24] ? 24'(-err) : err[23:0];
                    diff_neg_next = diff[24];
                    diff_mag_next = diff[24] ? 24'(-diff) : diff[23:0];
                    rate_next     = loop_rate_hz;
                    int_en_next   = (err > -vpp_pkg::ERR_WIN) && (err < vpp_pkg::ERR_WIN);
                    prev_next     = airway_pressure;
                    sum_next      = vpp_pkg::SUM_BIAS;
                end
            end
            vpp_pkg::ST_DMUL:
            begin
                dmag_next  = mul_p[39:0];
                op_next    = vpp_pkg::OP_PROP;
                chunk_next = vpp_pkg::CHUNK_ERR_TOP;
                acc_next   = '0;
            end
            vpp_pkg::ST_MUL:
            begin
                acc_next = acc_shift;
                if (chunk_reg != 2'd0)
                begin
                    chunk_next = chunk_reg - 2'd1;
                end
            end
            vpp_pkg::ST_FOLD:
            begin
                acc_next = '0;
                case (op_reg)
                    vpp_pkg::OP_PROP:
                    begin
                        sum_next   = sum_reg + term;
                        op_next    = vpp_pkg::OP_INT;
                        chunk_next = vpp_pkg::CHUNK_ERR_TOP;
                    end
                    vpp_pkg::OP_INT:
                    begin
                        if (int_en_reg)
                        begin
                            if (int_sum > vpp_pkg::ACC_MAX)
                            begin
                                integ_next = vpp_pkg::ACC_MAX[vpp_pkg::ACC_W-1:0];
                            end
                            else if (int_sum < vpp_pkg::ACC_MIN)
                            begin
                                integ_next = vpp_pkg::ACC_MIN[vpp_pkg::ACC_W-1:0];
                            end
                            else
                            begin
                                integ_next = int_sum[vpp_pkg::ACC_W-1:0];
                            end
                        end
                        op_next    = vpp_pkg::OP_DERIV;
                        chunk_next = vpp_pkg::CHUNK_DERIV_TOP;
                    end
                    vpp_pkg::OP_DERIV:
                    begin
                        sum_next = sum_reg - term;
                    end
                    default: ;
                endcase
            end
            vpp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    // Clamping on the Q.8 sum matches clamping the floored pulse.
                    if (total >= vpp_pkg::SUM_HI)
                    begin
                        blower_next = vpp_pkg::ESC_PULSE_MAX;
                    end
                    else if (total < vpp_pkg::SUM_LO)
                    begin
                        blower_next = vpp_pkg::ESC_PULSE_MIN;
                    end
                    else
                    begin
                        blower_next = total[19:8];
                    end
                    valve_next = (phase_reg == vpp_pkg::PHASE_INHALE) ?
                                 vpp_pkg::VALVE_CLOSED_PULSE : vpp_pkg::VALVE_OPEN_PULSE;
                    out_phase_next = phase_reg;
                    restart_next   = (phase_reg == vpp_pkg::PHASE_CYCLE_END);
                end
            end
            default: ;
        endcase
    end

    // Control state and PID state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vpp_pkg::ST_IDLE;
            op_reg        <= vpp_pkg::OP_PROP;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        err_mag_reg   <= err_mag_next;
        err_neg_reg   <= err_neg_next;
        diff_mag_reg  <= diff_mag_next;
        diff_neg_reg  <= diff_neg_next;
        rate_reg      <= rate_next;
        int_en_reg    <= int_en_next;
        dmag_reg      <= dmag_next;
        phase_reg     <= phase_next;
        blower_reg    <= blower_next;
        valve_reg     <= valve_next;
        out_phase_reg <= out_phase_next;
        restart_reg   <= restart_next;
    end

endmodule

@@ design/vpp_checker.sv @@
`timescale 1ns / 1ps

module vpp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [11:0]        blower_pulse_us,
    input logic [11:0]        valve_pulse_us,
    input logic [1:0]         phase,
    input logic               restart_cycle
);

    // One request at a time: the block is busy right after taking a request.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while the previous one is still in work");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blower_pulse_us >= vpp_pkg::ESC_PULSE_MIN &&
                      blower_pulse_us <= vpp_pkg::ESC_PULSE_MAX)
        else $error("blower pulse outside the ESC limits");

    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> restart_cycle == (phase == vpp_pkg::PHASE_CYCLE_END))
        else $error("restart flag disagrees with the phase");

    a_valve_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase == vpp_pkg::PHASE_INHALE &&
                       valve_pulse_us == vpp_pkg::VALVE_CLOSED_PULSE) ||
                      (phase != vpp_pkg::PHASE_INHALE &&
                       valve_pulse_us == vpp_pkg::VALVE_OPEN_PULSE))
        else $error("valve pulse disagrees with the phase");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(blower_pulse_us) && $stable(phase))
        else $error("stalled result changed");

endmodule

bind ventilator_pressure_pid vpp_checker u_vpp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .blower_pulse_us (blower_pulse_us),
    .valve_pulse_us  (valve_pulse_us),
    .phase           (phase),
    .restart_cycle   (restart_cycle)
);

@@ dv/tb_ventilator_pressure_pid.sv @@
`timescale 1ns / 1ps

module tb_ventilator_pressure_pid;
    import vpp_pkg::*;

    typedef struct packed {
        logic [11:0] blower;
        logic [11:0] valve;
        logic [1:0]  phase;
        logic        restart;
    } pulse_result_t;

    typedef struct packed {
        logic [15:0]        cycle_ms;
        logic [13:0]        rate_hz;
        logic signed [23:0] pressure;
        bit                 has_fixed;
        pulse_result_t      fixed;
    } tick_row_t;

    localparam longint PULSE_BIAS_Q8 = 64'sd256000;
    localparam longint ERR_WINDOW    = 64'sd256000;
    localparam longint INTEG_MAX     = 64'sd549755813887;
    localparam longint INTEG_MIN     = -64'sd549755813888;

    localparam int SET_REALISTIC = 0;
    localparam int SET_WILD      = 1;
    localparam int SET_EXTREME   = 2;

    // With all gains at zero the blower sits at its 1000 us bias.
    localparam pulse_result_t REST_INHALE = '{12'd1000, VALVE_CLOSED_PULSE, PHASE_INHALE, 1'b0};
    localparam pulse_result_t REST_EXHALE = '{12'd1000, VALVE_OPEN_PULSE, PHASE_EXHALE, 1'b0};
    localparam pulse_result_t REST_END    = '{12'd1000, VALVE_OPEN_PULSE, PHASE_CYCLE_END, 1'b1};

    localparam int DIR_ROWS          = 23;
    localparam int FIRST_TUNED_ROW   = 7;
    localparam int FIRST_EXTREME_ROW = 19;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        cycle_time_ms = '0;
    logic [13:0]        loop_rate_hz = '0;
    logic signed [23:0] airway_pressure = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [11:0]        blower_pulse_us;
    logic [11:0]        valve_pulse_us;
    logic [1:0]         phase;
    logic               restart_cycle;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // Predictor copy of the registers and the PID state.
    logic signed [31:0] gain_p = '0;
    logic signed [31:0] gain_i = '0;
    logic signed [31:0] gain_d = '0;
    logic [22:0]        peak_q8 = '0;
    logic [22:0]        base_q8 = '0;
    logic [15:0]        set_rise = 16'd0;
    logic [15:0]        set_inhale = 16'd1000;
    logic [15:0]        set_exhale = 16'd2000;
    longint             integ_q8 = 0;
    longint             last_pressure = 0;

    pulse_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int phase_seen [4] = '{0, 0, 0, 0};

    logic [31:0] tuned_words [8] = '{32'h0004_0000, 32'h0000_1000, 32'h0000_0400, 32'd6400,
                                     32'd1280, 32'd100, 32'd40000, 32'd30000};
    logic [31:0] extreme_words [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0000_FFFF,
                                       32'h0000_FFFF};

    tick_row_t dir_rows [DIR_ROWS] = '{
        // Reset settings, gains at zero.
        '{16'd0,     14'd0,     24'sd0,         1'b1, REST_END},
        '{16'd1,     14'd16383, 24'h7FFFFF,     1'b1, REST_INHALE},
        '{16'd1000,  14'd1,     24'h800000,     1'b1, REST_INHALE},
        '{16'd1001,  14'd10000, 24'h7FFFFF,     1'b1, REST_EXHALE},
        '{16'd3000,  14'd0,     24'sd0,         1'b1, REST_EXHALE},
        '{16'd3001,  14'd16383, 24'h800000,     1'b1, REST_END},
        '{16'd65535, 14'd5000,  24'sd1234,      1'b1, REST_END},
        // Tuned gains; the exhale window runs past 65535 ms.
        '{16'd100,   14'd100,   24'sd1280,      1'b0, '0},
        '{16'd101,   14'd100,   24'sd6000,      1'b0, '0},
        '{16'd20000, 14'd0,     24'sd6400,      1'b0, '0},
        '{16'd40000, 14'd200,   24'sd5000,      1'b0, '0},
        '{16'd40001, 14'd200,   24'sd1000,      1'b0, '0},
        '{16'd65535, 14'd16383, 24'sd2000,      1'b0, '0},
        '{16'd30000, 14'd1,     24'h800000,     1'b0, '0},
        '{16'd30001, 14'd10000, 24'h7FFFFF,     1'b0, '0},
        '{16'd50000, 14'd500,   -24'sd254719,   1'b0, '0},
        '{16'd50000, 14'd500,   -24'sd254720,   1'b0, '0},
        '{16'd50000, 14'd500,   24'sd257279,    1'b0, '0},
        '{16'd50000, 14'd500,   24'sd257280,    1'b0, '0},
        // Gains, targets and windows at their limits.
        '{16'd1,     14'd16383, 24'h800000,     1'b0, '0},
        '{16'd65535, 14'd16383, 24'h7FFFFF,     1'b0, '0},
        '{16'd0,     14'd0,     24'sd0,         1'b0, '0},
        '{16'd32768, 14'd8192,  24'sd100,       1'b0, '0}
    };

    ventilator_pressure_pid u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cycle_time_ms   (cycle_time_ms),
        .loop_rate_hz    (loop_rate_hz),
        .airway_pressure (airway_pressure),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .blower_pulse_us (blower_pulse_us),
        .valve_pulse_us  (valve_pulse_us),
        .phase           (phase),
        .restart_cycle   (restart_cycle),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // trunc(g * x / 65536), formed at full width.
    function automatic longint gain_product(input logic signed [31:0] g, input longint x);
        logic signed [79:0] ga;
        logic signed [79:0] xa;
        logic signed [79:0] full;
        ga = g;
        xa = x;
        full = (ga * xa) / 80'sd65536;
        return longint'(full);
    endfunction

    function automatic pulse_result_t predict_tick(input logic [15:0] t, input logic [13:0] rate,
                                                   input logic signed [23:0] pres);
        logic [16:0]   exh_end;
        longint        target;
        longint        err;
        longint        prop;
        longint        deriv;
        longint        sum;
        longint        pulse;
        longint        delta;
        pulse_result_t r;
        exh_end = {1'b0, set_inhale} + {1'b0, set_exhale};
        if (t > set_rise && t <= set_inhale)
        begin
            r.phase = PHASE_INHALE;
            r.valve = VALVE_CLOSED_PULSE;
            target  = longint'(peak_q8);
        end
        else if (t > set_inhale && {1'b0, t} <= exh_end)
        begin
            r.phase = PHASE_EXHALE;
            r.valve = VALVE_OPEN_PULSE;
            target  = longint'(base_q8);
        end
        else
        begin
            r.phase = PHASE_CYCLE_END;
            r.valve = VALVE_OPEN_PULSE;
            target  = longint'(base_q8);
        end
        r.restart = (r.phase == PHASE_CYCLE_END);

        err  = target - longint'(pres);
        prop = gain_product(gain_p, err);
        // The integral only moves while the error is inside the window.
        if (err > -ERR_WINDOW && err < ERR_WINDOW)
        begin
            integ_q8 = integ_q8 + gain_product(gain_i, err);
            if (integ_q8 > INTEG_MAX)
                integ_q8 = INTEG_MAX;
            if (integ_q8 < INTEG_MIN)
                integ_q8 = INTEG_MIN;
        end
        delta = (longint'(pres) - last_pressure) * longint'(rate);
        deriv = gain_product(gain_d, delta);
        last_pressure = longint'(pres);

        sum   = PULSE_BIAS_Q8 + prop + integ_q8 - deriv;
        pulse = sum >>> 8;
        if (pulse > longint'(ESC_PULSE_MAX))
            pulse = longint'(ESC_PULSE_MAX);
        if (pulse < longint'(ESC_PULSE_MIN))
            pulse = longint'(ESC_PULSE_MIN);
        r.blower = pulse[11:0];
        return r;
    endfunction

    task automatic drive_tick(input logic [15:0] t, input logic [13:0] rate,
                              input logic signed [23:0] pres, input bit has_fixed,
                              input pulse_result_t fixed);
        pulse_result_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        cycle_time_ms   <= t;
        loop_rate_hz    <= rate;
        airway_pressure <= pres;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = predict_tick(t, rate, pres);
        pending_results.push_back(has_fixed ? fixed : want);
        ticks_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GAIN_PROP:       gain_p = data;
            REG_GAIN_INT:        gain_i = data;
            REG_GAIN_DERIV:      gain_d = data;
            REG_PEAK_TARGET:     peak_q8 = data[22:0];
            REG_BASELINE_TARGET: base_q8 = data[22:0];
            REG_RISE_DELAY_MS:   set_rise = data[15:0];
            REG_INHALE_MS:       set_inhale = data[15:0];
            REG_EXHALE_MS:       set_exhale = data[15:0];
            default:             ;
        endcase
    endtask

    // Registers change only once the block has drained every request.
    task automatic apply_setting(input logic [31:0] words [8]);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 8; i++)
            write_reg(cfg_idx_t'(i), words[i]);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [31:0] rand_gain(input int unsigned mag);
        logic [31:0] g;
        g = $urandom_range(mag);
        if ($urandom_range(3) == 0)
            g = -g;
        return g;
    endfunction

    function automatic logic [31:0] extreme_gain();
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic random_setting(input int kind);
        logic [31:0] w [8];
        if (kind == SET_REALISTIC)
        begin
            w[REG_GAIN_PROP]       = rand_gain(32 << 16);
            w[REG_GAIN_INT]        = rand_gain(1 << 13);
            w[REG_GAIN_DERIV]      = rand_gain(1 << 12);
            w[REG_PEAK_TARGET]     = $urandom_range(60 * 256, 10 * 256);
            w[REG_BASELINE_TARGET] = $urandom_range(10 * 256);
            w[REG_RISE_DELAY_MS]   = $urandom_range(300);
            w[REG_INHALE_MS]       = w[REG_RISE_DELAY_MS] + $urandom_range(3000, 200);
            w[REG_EXHALE_MS]       = $urandom_range(4000, 200);
        end
        else if (kind == SET_WILD)
        begin
            for (int i = 0; i < 8; i++)
                w[i] = $urandom();
        end
        else
        begin
            w[REG_GAIN_PROP]       = extreme_gain();
            w[REG_GAIN_INT]        = extreme_gain();
            w[REG_GAIN_DERIV]      = extreme_gain();
            w[REG_PEAK_TARGET]     = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            w[REG_BASELINE_TARGET] = $urandom_range(1) ? 32'h007F_FFFF : 32'h0;
            w[REG_RISE_DELAY_MS]   = $urandom_range(2) == 0 ? 32'h0000_FFFF : 32'h0;
            w[REG_INHALE_MS]       = $urandom_range(1) ? 32'h0000_FFFF : 32'h0;
            w[REG_EXHALE_MS]       = $urandom_range(1) ? 32'h0000_FFFF : 32'h0;
        end
        apply_setting(w);
    endtask

    // Mostly breaths that sweep the cycle timer with pressure chasing the
    // target, the rest arbitrary ticks and phase boundary hits.
    task automatic run_random(input int count);
        int          sweep_t;
        int          sweep_p;
        int          tgt;
        int          exh_end;
        logic [15:0] edge_t;
        sweep_t = 0;
        sweep_p = int'(base_q8);
        exh_end = int'({1'b0, set_inhale} + {1'b0, set_exhale});
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(9) < 7)
            begin
                sweep_t = sweep_t + int'($urandom_range(exh_end / 40 + 1, 1));
                if (sweep_t > exh_end || sweep_t > 65535)
                    sweep_t = 0;
                tgt = (sweep_t > int'(set_rise) && sweep_t <= int'(set_inhale)) ?
                      int'(peak_q8) : int'(base_q8);
                sweep_p = sweep_p + (tgt - sweep_p) / 4 + int'($urandom_range(600)) - 300;
                if (sweep_p > 8388607)
                    sweep_p = 8388607;
                if (sweep_p < -8388608)
                    sweep_p = -8388608;
                drive_tick(16'(sweep_t), 14'($urandom_range(1000, 50)), 24'(sweep_p),
                           1'b0, '0);
            end
            else if ($urandom_range(2) == 0)
            begin
                case ($urandom_range(5))
                    0:       edge_t = set_rise;
                    1:       edge_t = set_rise + 16'd1;
                    2:       edge_t = set_inhale;
                    3:       edge_t = set_inhale + 16'd1;
                    4:       edge_t = 16'(exh_end);
                    default: edge_t = 16'(exh_end + 1);
                endcase
                drive_tick(edge_t, 14'($urandom_range(16383)), 24'($urandom()), 1'b0, '0);
            end
            else
            begin
                drive_tick(16'($urandom()), 14'($urandom_range(16383)), 24'($urandom()),
                           1'b0, '0);
            end
        end
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        pulse_result_t got;
        pulse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{blower_pulse_us, valve_pulse_us, phase, restart_cycle};
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: blower %0d valve %0d phase %0d restart %0d",
                         $time, got.blower, got.valve, got.phase, got.restart);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: expected blower %0d valve %0d phase %0d restart %0d",
                             $time, want.blower, want.valve, want.phase, want.restart);
                    $display("%0t           actual   blower %0d valve %0d phase %0d restart %0d",
                             $time, got.blower, got.valve, got.phase, got.restart);
                    error_count++;
                end
                results_checked++;
                phase_seen[got.phase]++;
            end
        end
    end

    initial
    begin
        #(2_000_000);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        send_idle_pct  = 25;
        recv_stall_pct = 83;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == FIRST_TUNED_ROW)
                apply_setting(tuned_words);
            if (i == FIRST_EXTREME_ROW)
                apply_setting(extreme_words);
            drive_tick(dir_rows[i].cycle_ms, dir_rows[i].rate_hz, dir_rows[i].pressure,
                       dir_rows[i].has_fixed, dir_rows[i].fixed);
        end

        for (int seg = 0; seg < 3; seg++)
        begin
            send_idle_pct  = (seg == 0) ? 25 : (seg == 1) ? 83 : 0;
            recv_stall_pct = (seg == 0) ? 83 : (seg == 1) ? 25 : 0;
            for (int j = 0; j < 4; j++)
            begin
                random_setting(j == 2 ? SET_WILD : j == 3 ? SET_EXTREME : SET_REALISTIC);
                run_random(146);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d results from %0d ticks under %0d register settings, %0d errors",
                 results_checked, ticks_sent, settings_applied, error_count);
        $display("Phases seen: inhale %0d, exhale %0d, cycle end %0d",
                 phase_seen[PHASE_INHALE], phase_seen[PHASE_EXHALE],
                 phase_seen[PHASE_CYCLE_END]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ ventilator_pressure_pid.f @@
design/vpp_pkg.sv
design/ventilator_pressure_pid.sv
design/vpp_checker.sv
dv/tb_ventilator_pressure_pid.sv
